// ===== design/clfb_pkg.sv =====
// Package for the CAN log frame builder: constants, result codes and the
// command word that the front end hands to the byte serializer.
// No dependencies.
package clfb_pkg;

	localparam int unsigned MAX_PAYLOAD_DEF   = 64;
	localparam int unsigned QUEUE_DEPTH_DEF   = 4;
	localparam int unsigned FRAME_OVERHEAD    = 16;
	localparam logic [2:0]  MAX_CHANNEL       = 3'd2;
	localparam logic [7:0]  START_BYTE        = 8'hFF;
	localparam logic [7:0]  MAX_FRAME_LEN_RST = 8'd80;
	localparam logic [15:0] SEQ_MASK          = 16'h00FF;
	localparam logic [3:0]  HDR_LAST_IDX      = 4'd14;
	localparam logic [3:0]  HDR_CHK_IDX       = 4'd15;

	// Register index, taken from paddr[2]
	localparam logic REG_MAX_FRAME_LEN = 1'b0;

	localparam logic OP_HEADER  = 1'b0;
	localparam logic OP_PAYLOAD = 1'b1;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_BAD_CHANNEL = 3'd1,
		ST_TOO_LONG    = 3'd2,
		ST_TOO_BIG     = 3'd3,
		ST_UNEXPECTED  = 3'd4,
		ST_HDR_OPEN    = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		CMD_ERR  = 2'd0,
		CMD_HDR  = 2'd1,
		CMD_DATA = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic        close;        // checksum follows this command
		status_t     status;
		logic [7:0]  data_byte;
		logic [15:0] seq;
		logic [31:0] timestamp;
		logic [31:0] msg_id;
		logic [7:0]  type_chan;
		logic [7:0]  payload_len;
	} cmd_t;

	typedef struct packed {
		logic open;
		logic rem_zero;
	} front_stat_t;

endpackage

// ===== design/clfb_in_if.sv =====
// Input channel of the CAN log frame builder: handshake and item fields.
// No dependencies.
interface clfb_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [2:0]  channel;
	logic        is_tx;
	logic        is_fd;
	logic [31:0] msg_id;
	logic [7:0]  payload_len;
	logic [31:0] timestamp;
	logic [7:0]  data_byte;

	modport source (output valid, op, channel, is_tx, is_fd, msg_id, payload_len,
		timestamp, data_byte, input ready);
	modport sink (input valid, op, channel, is_tx, is_fd, msg_id, payload_len,
		timestamp, data_byte, output ready);
endinterface

// ===== design/clfb_out_if.sv =====
// Output channel of the CAN log frame builder: one frame byte per transfer.
// No dependencies.
interface clfb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;
	logic [2:0] status;

	modport source (output valid, out_byte, last, status, input ready);
	modport sink (input valid, out_byte, last, status, output ready);
endinterface

// ===== design/clfb_front.sv =====
// Front end: accepts input items, checks them against the frame state and
// issues one command per item. Depends on clfb_pkg and clfb_in_if.
module clfb_front #(
	parameter int unsigned MaxPayload = clfb_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	clfb_in_if.sink               msg,
	input  logic [7:0]            max_frame_len,
	input  logic                  q_full,
	output logic                  push,
	output clfb_pkg::cmd_t        cmd,
	output clfb_pkg::front_stat_t stat
);
	import clfb_pkg::*;

	localparam int unsigned RemW = $clog2(MaxPayload + 1);

	logic            open_q;
	logic [RemW-1:0] rem_q;
	logic [15:0]     seq_q;
	logic            open_d;
	logic [RemW-1:0] rem_d;
	logic [15:0]     seq_d;
	logic [8:0]      total_len;

	assign msg.ready = !q_full;
	assign push      = msg.valid && msg.ready;
	assign total_len = {1'b0, msg.payload_len} + 9'(FRAME_OVERHEAD);

	always_comb begin
		cmd             = '0;
		cmd.kind        = CMD_ERR;
		cmd.status      = ST_OK;
		cmd.data_byte   = msg.data_byte;
		cmd.seq         = seq_q;
		cmd.timestamp   = msg.timestamp;
		cmd.msg_id      = msg.msg_id;
		cmd.type_chan   = {msg.channel, 3'b000, msg.is_fd, msg.is_tx};
		cmd.payload_len = msg.payload_len;
		open_d          = open_q;
		rem_d           = rem_q;
		seq_d           = seq_q;
		if (msg.op == OP_PAYLOAD) begin
			if (!open_q) begin
				cmd.status = ST_UNEXPECTED;
			end else begin
				cmd.kind  = CMD_DATA;
				cmd.close = (rem_q == RemW'(1));
				rem_d     = rem_q - RemW'(1);
				open_d    = (rem_q != RemW'(1));
			end
		end else if (open_q) begin
			cmd.status = ST_HDR_OPEN;
		end else if (msg.channel > MAX_CHANNEL) begin
			cmd.status = ST_BAD_CHANNEL;
		end else if (msg.payload_len > 8'(MaxPayload)) begin
			cmd.status = ST_TOO_LONG;
		end else if (total_len > {1'b0, max_frame_len}) begin
			cmd.status = ST_TOO_BIG;
		end else begin
			cmd.kind  = CMD_HDR;
			cmd.close = (msg.payload_len == 8'd0);
			seq_d     = seq_q + 16'd1;
			open_d    = (msg.payload_len != 8'd0);
			rem_d     = msg.payload_len[RemW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			rem_q  <= '0;
			seq_q  <= '0;
		end else if (push) begin
			open_q <= open_d;
			rem_q  <= rem_d;
			seq_q  <= seq_d;
		end
	end

	assign stat.open     = open_q;
	assign stat.rem_zero = (rem_q == '0);
endmodule

// ===== design/clfb_queue.sv =====
// Short command queue between the front end and the serializer.
// Depends on clfb_pkg.
module clfb_queue #(
	parameter int unsigned Depth = clfb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  clfb_pkg::cmd_t wr_cmd,
	input  logic           pop,
	output clfb_pkg::cmd_t head,
	output logic           full,
	output logic           empty
);
	import clfb_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	cmd_t            slot_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full  = (count_q == CntW'(Depth));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end
endmodule

// ===== design/clfb_back.sv =====
// Serializer: turns each queued command into frame bytes, keeps the running
// byte sum and appends the checksum. Depends on clfb_pkg and clfb_out_if.
module clfb_back (
	input  logic           clk,
	input  logic           arst_n,
	input  clfb_pkg::cmd_t head,
	input  logic           empty,
	output logic           pop,
	clfb_out_if.source     stream
);
	import clfb_pkg::*;

	logic [3:0] idx_q;
	logic [7:0] sum_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	status_t    status_q;

	logic       adv;
	logic [3:0] last_idx;
	logic       is_chk;
	logic [7:0] hdr_byte;
	logic [7:0] nxt_byte;
	logic [8:0] total_len;

	assign adv       = !empty && (!valid_q || stream.ready);
	assign total_len = {1'b0, head.payload_len} + 9'(FRAME_OVERHEAD);

	always_comb begin
		case (head.kind)
			CMD_HDR:  last_idx = head.close ? HDR_CHK_IDX : HDR_LAST_IDX;
			CMD_DATA: last_idx = head.close ? 4'd1 : 4'd0;
			default:  last_idx = 4'd0;
		endcase
	end

	assign pop    = adv && (idx_q == last_idx);
	assign is_chk = ((head.kind == CMD_HDR) && (idx_q == HDR_CHK_IDX)) ||
		((head.kind == CMD_DATA) && (idx_q == 4'd1));

	always_comb begin
		case (idx_q)
			4'd0:    hdr_byte = START_BYTE;
			4'd1:    hdr_byte = total_len[7:0];
			4'd2:    hdr_byte = {7'd0, total_len[8]};
			4'd3:    hdr_byte = 8'(head.seq & SEQ_MASK);
			4'd4:    hdr_byte = head.seq[15:8];
			4'd5:    hdr_byte = head.timestamp[7:0];
			4'd6:    hdr_byte = head.timestamp[15:8];
			4'd7:    hdr_byte = head.timestamp[23:16];
			4'd8:    hdr_byte = head.timestamp[31:24];
			4'd9:    hdr_byte = head.type_chan;
			4'd10:   hdr_byte = head.msg_id[7:0];
			4'd11:   hdr_byte = head.msg_id[15:8];
			4'd12:   hdr_byte = head.msg_id[23:16];
			4'd13:   hdr_byte = head.msg_id[31:24];
			default: hdr_byte = head.payload_len;
		endcase
	end

	always_comb begin
		if (is_chk) begin
			nxt_byte = 8'd0 - sum_q;
		end else begin
			case (head.kind)
				CMD_HDR:  nxt_byte = hdr_byte;
				CMD_DATA: nxt_byte = head.data_byte;
				default:  nxt_byte = 8'd0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			sum_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (adv) begin
				valid_q <= 1'b1;
				idx_q   <= pop ? 4'd0 : idx_q + 4'd1;
				if (is_chk) begin
					sum_q <= '0;
				end else if (head.kind == CMD_HDR && idx_q == 4'd0) begin
					sum_q <= nxt_byte;
				end else if (head.kind != CMD_ERR) begin
					sum_q <= sum_q + nxt_byte;
				end
			end else if (stream.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_q   <= nxt_byte;
			last_q   <= is_chk || (head.kind == CMD_ERR);
			status_q <= (head.kind == CMD_ERR) ? head.status : ST_OK;
		end
	end

	assign stream.valid    = valid_q;
	assign stream.out_byte = byte_q;
	assign stream.last     = last_q;
	assign stream.status   = status_q;
endmodule

// ===== design/can_log_frame_builder_top.sv =====
// CAN log frame builder, top level. The first byte of an item's results
// passes through the queue slot and the registered output stage before it
// is on offer, when both are empty. Throughput: one input transfer per
// cycle while the queue has room; the serializer gives one byte per cycle
// unless the output stalls, and a header is 15 or 16 bytes. Reset (arst_n,
// asynchronous) clears the control state and sets max_frame_len to 80.
module can_log_frame_builder_top #(
	parameter int unsigned MaxPayload = clfb_pkg::MAX_PAYLOAD_DEF,
	parameter int unsigned QueueDepth = clfb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	clfb_in_if.sink     msg,
	clfb_out_if.source  stream,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import clfb_pkg::*;

	// The configuration register. Writes are only expected while the block
	// is idle, so the front end can read it without any synchronisation.
	logic [7:0]  max_frame_len_q;

	// Front end to queue.
	logic        push;
	cmd_t        wr_cmd;
	logic        q_full;
	front_stat_t fr_stat;

	// Queue to serializer.
	cmd_t        head;
	logic        q_empty;
	logic        pop;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MAX_FRAME_LEN) ? {24'd0, max_frame_len_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_len_q <= MAX_FRAME_LEN_RST;
		end else if (psel && penable && pwrite && paddr[2] == REG_MAX_FRAME_LEN) begin
			max_frame_len_q <= pwdata[7:0];
		end
	end

	// The front end classifies every transfer at once and updates the frame
	// state (open flag, bytes still expected, sequence number), so each input
	// item becomes exactly one command in the queue, errors included.
	clfb_front #(
		.MaxPayload(MaxPayload)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg          (msg),
		.max_frame_len(max_frame_len_q),
		.q_full       (q_full),
		.push         (push),
		.cmd          (wr_cmd),
		.stat         (fr_stat)
	);

	// A short queue lets payload bytes keep arriving while the serializer is
	// still draining a header.
	clfb_queue #(
		.Depth(QueueDepth)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wr_cmd(wr_cmd),
		.pop   (pop),
		.head  (head),
		.full  (q_full),
		.empty (q_empty)
	);

	// The serializer walks through the bytes of the command at the head of the
	// queue, one per cycle unless stalled, into a registered output stage.
	clfb_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.empty (q_empty),
		.pop   (pop),
		.stream(stream)
	);

	// A frame is open exactly while payload bytes are still expected.
	assert property (@(posedge clk) disable iff (!arst_n)
		fr_stat.open == !fr_stat.rem_zero)
		else $error("frame open flag disagrees with remaining byte count");

	// Every error result is a single zero byte that closes the transfer group.
	assert property (@(posedge clk) disable iff (!arst_n)
		(stream.valid && stream.status != ST_OK) |-> (stream.last && stream.out_byte == 8'd0))
		else $error("error result carries data or lacks last");

	// The serializer never takes a command from an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("command popped from empty queue");
endmodule

// ===== verif/tb_can_log_frame_builder_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for can_log_frame_builder_top: feeds CAN message items, writes the
// frame length limit over APB and checks every serialized frame byte against its own predictor.
// Depends on clfb_pkg, clfb_in_if, clfb_out_if and the can_log_frame_builder_top RTL.
module tb_can_log_frame_builder_top;
	import clfb_pkg::*;

	// The limit is far above the slowest legal run. That run has roughly 300 items at most
	// 16 bytes each, and the receiver stalls in up to 80 % of cycles.
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned TAIL_CYCLES = 20;
	localparam int unsigned MAX_REPORTS = 10;
	localparam int unsigned SEQ_RUN_HEADERS = 12;
	localparam logic [2:0]  MAX_FRAME_LEN_ADDR = {REG_MAX_FRAME_LEN, 2'b00};

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct packed {
		logic        op;
		logic [2:0]  channel;
		logic        is_tx;
		logic        is_fd;
		logic [31:0] msg_id;
		logic [7:0]  payload_len;
		logic [31:0] timestamp;
		logic [7:0]  data_byte;
	} can_msg_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		status_t    status;
	} frame_byte_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	clfb_in_if  msg ();
	clfb_out_if stream ();

	can_log_frame_builder_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.msg     (msg),
		.stream  (stream),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Items waiting to be driven, and the frame bytes the block still owes us, oldest first.
	can_msg_t    msgs_to_send[$];
	frame_byte_t frame_bytes_due[$];

	idle_mode_t  idle_mode = IDLE_NONE;
	logic        msg_taken = 1'b0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	// The predictor keeps its own copy of the limit register and of the frame state.
	logic [7:0]  max_frame_len_cfg = MAX_FRAME_LEN_RST;
	logic [15:0] seq_nr = '0;
	logic [7:0]  frame_sum = '0;
	logic [6:0]  payload_left = '0;
	logic        frame_is_open = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// The idling decision is made at most once per cycle for each side. Which side idles, and how
	// often, depends on the current phase.
	function automatic bit gap_now(input bit for_sender);
		int unsigned pct;
		case (idle_mode)
			IDLE_NONE:     pct = 0;
			IDLE_SENDER:   pct = for_sender ? 80 : 0;
			IDLE_RECEIVER: pct = for_sender ? 0 : 80;
			default:       pct = 14;
		endcase
		return $urandom_range(0, 99) < pct;
	endfunction

	// Only the first few mismatches are described. The rest are just counted, so that a
	// broken block cannot flood the log.
	function automatic void report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("Mismatch at %0t ns: %s", $time, what);
		end
	endfunction

	function automatic void expect_byte(input logic [7:0] b);
		frame_sum = frame_sum + b;
		frame_bytes_due.push_back('{out_byte: b, last: 1'b0, status: ST_OK});
	endfunction

	// The checksum is chosen so that the byte sum of the whole frame is zero modulo 256.
	// Sending it closes the frame.
	function automatic void expect_checksum();
		logic [7:0] chk;
		chk = 8'd0 - frame_sum;
		frame_bytes_due.push_back('{out_byte: chk, last: 1'b1, status: ST_OK});
		frame_sum = '0;
		payload_left = '0;
		frame_is_open = 1'b0;
	endfunction

	function automatic void expect_reject(input status_t code);
		frame_bytes_due.push_back('{out_byte: 8'h00, last: 1'b1, status: code});
	endfunction

	// This works out the frame bytes that one accepted item should produce. A rejected item
	// gives a single flagged byte and leaves every piece of frame state alone.
	function automatic void frame_byte_predict(input can_msg_t m);
		logic [15:0] total_len;
		total_len = 16'(m.payload_len) + 16'(FRAME_OVERHEAD);
		if (m.op == OP_PAYLOAD) begin
			if (!frame_is_open) begin
				expect_reject(ST_UNEXPECTED);
			end else begin
				expect_byte(m.data_byte);
				payload_left = payload_left - 7'd1;
				if (payload_left == '0) begin
					expect_checksum();
				end
			end
		end else if (frame_is_open) begin
			expect_reject(ST_HDR_OPEN);
		end else if (m.channel > MAX_CHANNEL) begin
			expect_reject(ST_BAD_CHANNEL);
		end else if (32'(m.payload_len) > MAX_PAYLOAD_DEF) begin
			expect_reject(ST_TOO_LONG);
		end else if (total_len > 16'(max_frame_len_cfg)) begin
			expect_reject(ST_TOO_BIG);
		end else begin
			frame_sum = '0;
			expect_byte(START_BYTE);
			expect_byte(total_len[7:0]);
			expect_byte(total_len[15:8]);
			expect_byte(seq_nr[7:0]);
			expect_byte(seq_nr[15:8]);
			seq_nr = seq_nr + 16'd1;
			for (int i = 0; i < 4; i++) begin
				expect_byte(m.timestamp[8*i +: 8]);
			end
			// The type code sits in the low five bits and the channel in the top three.
			expect_byte({m.channel, 3'b000, m.is_fd, m.is_tx});
			for (int i = 0; i < 4; i++) begin
				expect_byte(m.msg_id[8*i +: 8]);
			end
			expect_byte(m.payload_len);
			if (m.payload_len == 8'd0) begin
				expect_checksum();
			end else begin
				payload_left = m.payload_len[6:0];
				frame_is_open = 1'b1;
			end
		end
	endfunction

	// Fields that an op does not use still get random values. The block has to ignore them.
	function automatic can_msg_t random_msg();
		can_msg_t m;
		m.op          = 1'($urandom_range(0, 1));
		m.channel     = 3'($urandom_range(0, 7));
		m.is_tx       = 1'($urandom_range(0, 1));
		m.is_fd       = 1'($urandom_range(0, 1));
		m.msg_id      = $urandom;
		m.payload_len = 8'($urandom_range(0, 255));
		m.timestamp   = $urandom;
		m.data_byte   = 8'($urandom_range(0, 255));
		return m;
	endfunction

	function automatic can_msg_t header_msg(input logic [2:0] ch, input logic [7:0] len);
		can_msg_t m;
		m = random_msg();
		m.op = OP_HEADER;
		m.channel = ch;
		m.payload_len = len;
		return m;
	endfunction

	function automatic can_msg_t payload_msg(input logic [7:0] b);
		can_msg_t m;
		m = random_msg();
		m.op = OP_PAYLOAD;
		m.data_byte = b;
		return m;
	endfunction

	// Most of the traffic is well-formed frames with random content. Payload lengths are
	// mostly short, with some frames at the limit and some just over it. The remainder is
	// noise: bad headers, stray payload bytes, headers dropped into an open frame, and
	// frames cut short.
	task automatic random_traffic(input int unsigned n_items);
		int unsigned made;
		int unsigned pick;
		int unsigned len;
		int unsigned fit;
		made = 0;
		fit = (max_frame_len_cfg >= FRAME_OVERHEAD) ? max_frame_len_cfg - FRAME_OVERHEAD : 0;
		if (fit > MAX_PAYLOAD_DEF) begin
			fit = MAX_PAYLOAD_DEF;
		end
		while (made < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				pick = $urandom_range(0, 99);
				if (pick < 10) begin
					len = fit;
				end else if (pick < 20) begin
					len = (fit < MAX_PAYLOAD_DEF) ? fit + 1 : fit;
				end else if (pick < 40) begin
					len = $urandom_range(0, fit);
				end else begin
					len = $urandom_range(0, (fit < 6) ? fit : 6);
				end
				msgs_to_send.push_back(header_msg(3'($urandom_range(0, 2)), 8'(len)));
				made++;
				for (int unsigned i = 0; i < len; i++) begin
					if ($urandom_range(0, 99) < 3) begin
						break;
					end
					if ($urandom_range(0, 99) < 3) begin
						msgs_to_send.push_back(header_msg(3'($urandom_range(0, 7)),
							8'($urandom_range(0, 255))));
						made++;
					end
					msgs_to_send.push_back(payload_msg(8'($urandom_range(0, 255))));
					made++;
				end
			end else if (pick < 82) begin
				msgs_to_send.push_back(header_msg(3'($urandom_range(3, 7)),
					8'($urandom_range(0, 255))));
				made++;
			end else if (pick < 89) begin
				msgs_to_send.push_back(header_msg(3'($urandom_range(0, 2)),
					8'($urandom_range(65, 255))));
				made++;
			end else begin
				msgs_to_send.push_back(payload_msg(8'($urandom_range(0, 255))));
				made++;
			end
		end
	endtask

	// This waits until the block has nothing more to do: no item is queued or on offer, and
	// no frame byte is still owed. Every item produces at least one byte, so an empty queue
	// of expected bytes means the block is idle.
	task automatic wait_idle();
		while (msgs_to_send.size() != 0 || msg.valid || frame_bytes_due.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// This writes the frame length limit and then reads it back. Each access has a setup
	// phase and then an access phase, which completes on an edge where pready is high.
	task automatic reg_write(input logic [7:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= MAX_FRAME_LEN_ADDR;
		pwdata <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		max_frame_len_cfg = value;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[7:0] !== value) begin
			report_mismatch($sformatf("max_frame_len read back %02h, expected %02h",
				prdata[7:0], value));
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_phase(input logic [7:0] limit, input idle_mode_t mode,
		input int unsigned n_items);
		reg_write(limit);
		idle_mode = mode;
		random_traffic(n_items);
		wait_idle();
	endtask

	// The driver presents a new item only when the previous one has made its transfer, or
	// when nothing is on offer. An item that is on offer stays put until it is taken.
	always @(negedge clk) begin : msg_driver
		can_msg_t m;
		if (!arst_n) begin
			msg.valid <= 1'b0;
		end else if (!msg.valid || msg_taken) begin
			if (msgs_to_send.size() != 0 && !gap_now(1'b1)) begin
				m = msgs_to_send.pop_front();
				msg.valid <= 1'b1;
				msg.op <= m.op;
				msg.channel <= m.channel;
				msg.is_tx <= m.is_tx;
				msg.is_fd <= m.is_fd;
				msg.msg_id <= m.msg_id;
				msg.payload_len <= m.payload_len;
				msg.timestamp <= m.timestamp;
				msg.data_byte <= m.data_byte;
			end else begin
				msg.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : byte_sink
		stream.ready <= arst_n && !gap_now(1'b0);
	end

	// On each rising edge the monitor first checks any byte transfer against the oldest
	// expected byte. It then feeds an accepted item to the predictor. A byte can never
	// belong to an item accepted on the same edge.
	always @(posedge clk) begin : byte_monitor
		frame_byte_t want;
		if (!arst_n) begin
			msg_taken = 1'b0;
		end else if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d bytes still expected", cycles,
				frame_bytes_due.size());
			$display("Simulation FAILED");
			$finish;
		end else begin
			cycles++;
			if (stream.valid && stream.ready) begin
				if (frame_bytes_due.size() == 0) begin
					report_mismatch($sformatf("byte %02h last %0b status %0d with none expected",
						stream.out_byte, stream.last, stream.status));
				end else begin
					want = frame_bytes_due.pop_front();
					if (stream.out_byte !== want.out_byte || stream.last !== want.last ||
						stream.status !== want.status) begin
						report_mismatch($sformatf(
							"got byte %02h last %0b status %0d, expected %02h last %0b status %0d",
							stream.out_byte, stream.last, stream.status,
							want.out_byte, want.last, want.status));
					end
				end
			end
			msg_taken = msg.valid && msg.ready;
			if (msg_taken) begin
				frame_byte_predict('{op: msg.op, channel: msg.channel, is_tx: msg.is_tx,
					is_fd: msg.is_fd, msg_id: msg.msg_id, payload_len: msg.payload_len,
					timestamp: msg.timestamp, data_byte: msg.data_byte});
			end
		end
	end

	initial begin : stimulus
		can_msg_t m;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		msg.valid = 1'b0;
		msg.op = OP_HEADER;
		msg.channel = '0;
		msg.is_tx = 1'b0;
		msg.is_fd = 1'b0;
		msg.msg_id = '0;
		msg.payload_len = '0;
		msg.timestamp = '0;
		msg.data_byte = '0;
		stream.ready = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, run at the reset limit of 80 bytes with no idling. It starts with
		// empty frames whose fields are all zeros and then all ones.
		m = header_msg(3'd0, 8'd0);
		m.is_tx = 1'b0;
		m.is_fd = 1'b0;
		m.msg_id = '0;
		m.timestamp = '0;
		msgs_to_send.push_back(m);
		m = header_msg(3'd2, 8'd0);
		m.is_tx = 1'b1;
		m.is_fd = 1'b1;
		m.msg_id = '1;
		m.timestamp = '1;
		msgs_to_send.push_back(m);
		// Next come a stray payload byte and the header rejects. A bad channel must be
		// reported before a bad length.
		msgs_to_send.push_back(payload_msg(8'hFF));
		msgs_to_send.push_back(header_msg(3'd3, 8'd0));
		msgs_to_send.push_back(header_msg(3'd7, 8'd255));
		msgs_to_send.push_back(header_msg(3'd1, 8'd65));
		msgs_to_send.push_back(header_msg(3'd2, 8'd255));
		// A header that arrives while a frame is open is refused, and the open frame
		// carries on as before.
		m = header_msg(3'd1, 8'd2);
		m.is_tx = 1'b1;
		m.is_fd = 1'b0;
		msgs_to_send.push_back(m);
		msgs_to_send.push_back(header_msg(3'd7, 8'd255));
		msgs_to_send.push_back(payload_msg(8'h00));
		msgs_to_send.push_back(payload_msg(8'hFF));
		m = header_msg(3'd0, 8'd1);
		m.is_tx = 1'b0;
		m.is_fd = 1'b1;
		msgs_to_send.push_back(m);
		msgs_to_send.push_back(payload_msg(8'h5A));
		wait_idle();

		// With the limit at 16 only empty frames fit, so a single payload byte is too big.
		// A short run of empty frames then follows back to back.
		reg_write(8'd16);
		msgs_to_send.push_back(header_msg(3'd1, 8'd1));
		msgs_to_send.push_back(payload_msg(8'h33));
		for (int i = 0; i < SEQ_RUN_HEADERS; i++) begin
			msgs_to_send.push_back(header_msg(3'($urandom_range(0, 2)), 8'd0));
		end
		wait_idle();

		// Random phases. The limit goes through the reset value and both extremes, and
		// each idling pattern is used in turn.
		run_phase(MAX_FRAME_LEN_RST, IDLE_NONE, 30);
		run_phase(8'd255, IDLE_SENDER, 35);
		run_phase(8'd0, IDLE_RECEIVER, 20);
		run_phase(8'd40, IDLE_RECEIVER, 30);
		run_phase(8'd255, IDLE_BOTH, 35);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
